/* rtl/lgt_pkg.sv */
// lgt_pkg: widths, fixed-point constants, sequencer states and divider status
// for the loudness gain tracker. No dependencies.
package lgt_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int AVG_W   = 25;
  localparam int GAIN_W  = 18;
  localparam int DB_W    = 13;
  localparam int TGT_W   = 16;
  localparam int QUO_W   = 30;
  localparam int FRAC_W  = 24;
  localparam int MUL_W   = 32;
  localparam int ACC_W   = 49;
  localparam int CNT_W   = 5;

  localparam logic [AVG_W-1:0]  AVG_OLD        = 25'd16760439;
  localparam logic [AVG_W-1:0]  AVG_NEW        = 25'd16777;
  localparam logic [AVG_W-1:0]  LOUD_THRESHOLD = 25'd1677;
  localparam logic [AVG_W-1:0]  GAIN_OLD       = 25'd16693330;
  localparam logic [AVG_W-1:0]  GAIN_NEW       = 25'd83886;
  localparam logic [GAIN_W-1:0] GAIN_MIN       = 18'd13107;
  localparam logic [GAIN_W-1:0] GAIN_MAX       = 18'd196608;
  localparam logic [GAIN_W-1:0] GAIN_ONE       = 18'd65536;
  localparam logic [27:0]       DB_PER_OCTAVE  = 28'd101008905;
  localparam logic [TGT_W-1:0]  TARGET_RESET   = 16'd9830;
  localparam logic [AVG_W-1:0]  AVG_FULL       = 25'd16777216;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_OLD,
    ST_AVG_NEW,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_GAIN_OLD,
    ST_GAIN_NEW,
    ST_LOG,
    ST_DB_MUL,
    ST_DONE
  } lgt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/lgt_if.sv */
// lgt_if: valid/ready channels for samples, results and the target register
// depends on lgt_pkg for field widths
interface lgt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [lgt_pkg::SAMPLE_WIDTH-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lgt_out_if;
  logic                              valid;
  logic                              ready;
  logic [lgt_pkg::GAIN_W-1:0]        gain;
  logic signed [lgt_pkg::DB_W-1:0]   gain_db;
  logic [lgt_pkg::AVG_W-1:0]         loudness;
  logic                              gain_updated;
  modport source (output valid, output gain, output gain_db, output loudness,
                  output gain_updated, input ready);
  modport sink (input valid, input gain, input gain_db, input loudness,
                input gain_updated, output ready);
endinterface

interface lgt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lgt_pkg::TGT_W-1:0]      target_level;
  modport source (output valid, output target_level, input ready);
  modport sink (input valid, input target_level, output ready);
endinterface

/* rtl/lgt_div.sv */
// lgt_div: restoring divider, (target << 24) / average, one quotient bit a cycle
// depends on lgt_pkg; the divisor is always above 1023 so the top 10 bits are zero
module lgt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lgt_pkg::TGT_W-1:0]   target,
  input  logic [lgt_pkg::AVG_W-1:0]   divisor,
  output lgt_pkg::div_stat_t          stat,
  output logic [lgt_pkg::QUO_W-1:0]   quotient
);
  logic [lgt_pkg::AVG_W-1:0] rem_r, rem_nxt;
  logic [lgt_pkg::QUO_W-1:0] shf_r, shf_nxt;
  logic [lgt_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [lgt_pkg::AVG_W-1:0] dvs_r, dvs_nxt;
  logic [lgt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [lgt_pkg::AVG_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, shf_r[lgt_pkg::QUO_W-1]};
    if (start) begin
      // high numerator bits are already below the divisor
      rem_nxt  = lgt_pkg::AVG_W'(target[lgt_pkg::TGT_W-1:6]);
      shf_nxt  = {target[5:0], 24'd0};
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = lgt_pkg::AVG_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[lgt_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[lgt_pkg::AVG_W-1:0];
        quo_nxt = {quo_r[lgt_pkg::QUO_W-2:0], 1'b0};
      end
      shf_nxt = {shf_r[lgt_pkg::QUO_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lgt_pkg::CNT_W'(lgt_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
endmodule

/* rtl/loudness_gain_tracker.sv */
// loudness_gain_tracker: automatic gain control with a shared 32x32 multiplier
// depends on lgt_pkg, the channel interfaces in lgt_if and the divider lgt_div
//
// Usage: in_bus carries one signed sample per beat; out_bus returns one beat per
// sample with the smoothed gain (Q2.16), its level in dB (Q5.8), the magnitude
// average (Q1.24) and a flag telling whether the gain was recomputed.
// cfg_bus writes the target level (Q0.16); it is always ready and should only
// be written while no sample is in flight.
// Sequence: a sample below the loudness threshold takes 2 multiply steps for
// the average and then goes to the result register; a sample that updates
// the gain also takes the divider, which works out its 30-bit quotient one
// bit at a time, 2 multiply steps for smoothing, 24 squaring steps of the log2
// on the shared multiplier and one dB multiply, plus sequencer hand-offs. One
// sample is worked on at a time; in_bus is ready only while the sequencer is
// idle, so a sample is taken only after the last result has left the sequencer.
// The result sits in an output register, so the next sample is accepted while
// a result waits; if the receiver stalls, the following result holds in the
// sequencer until the register frees up.
// Reset: average 0, gain 1.0, dB 0, target 0.15, no result pending.
module loudness_gain_tracker (
  input  logic        clk,
  input  logic        rst_n,
  lgt_in_if.sink      in_bus,
  lgt_out_if.source   out_bus,
  lgt_cfg_if.sink     cfg_bus
);
  localparam int SW = lgt_pkg::SAMPLE_WIDTH;

  lgt_pkg::lgt_state_t state_r, state_nxt;

  logic [lgt_pkg::TGT_W-1:0]  tgt_r;
  logic [lgt_pkg::AVG_W-1:0]  avg_r, avg_nxt;
  logic [lgt_pkg::AVG_W-1:0]  mag_r, mag_nxt;
  logic [lgt_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [lgt_pkg::DB_W-1:0]   db_r, db_nxt;
  logic                       upd_r, upd_nxt;
  logic [lgt_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [lgt_pkg::MUL_W-1:0]  m_r, m_nxt;
  logic [lgt_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic signed [2:0]          exp_r, exp_nxt;
  logic [lgt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                       ov_r, ov_nxt;
  logic [lgt_pkg::GAIN_W-1:0] og_r, og_nxt;
  logic [lgt_pkg::DB_W-1:0]   odb_r, odb_nxt;
  logic [lgt_pkg::AVG_W-1:0]  oavg_r, oavg_nxt;
  logic                       oupd_r, oupd_nxt;

  logic [lgt_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [2*lgt_pkg::MUL_W-1:0] prod;
  logic [lgt_pkg::ACC_W-1:0]  sum;
  logic [lgt_pkg::AVG_W-1:0]  g_raw;
  logic [lgt_pkg::GAIN_W-1:0] g_clamp;
  logic [4:0]                 e_pos;
  logic [31:0]                sq;
  logic signed [26:0]         l2;
  logic [26:0]                l2_abs;
  logic [52:0]                db_rnd;
  logic [lgt_pkg::DB_W-1:0]   db_mag;
  logic [SW:0]                abs_s;
  logic                       div_start;
  lgt_pkg::div_stat_t         div_stat;
  logic [lgt_pkg::QUO_W-1:0]  quo;
  logic                       in_acc;

  lgt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .target   (tgt_r),
    .divisor  (avg_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  assign prod   = mul_a * mul_b;
  assign sum    = acc_r + prod[lgt_pkg::ACC_W-1:0];
  assign in_acc = in_bus.valid && in_bus.ready;

  always_comb begin
    state_nxt = state_r;
    avg_nxt   = avg_r;
    mag_nxt   = mag_r;
    gain_nxt  = gain_r;
    db_nxt    = db_r;
    upd_nxt   = upd_r;
    acc_nxt   = acc_r;
    m_nxt     = m_r;
    frac_nxt  = frac_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_bus.ready;
    og_nxt    = og_r;
    odb_nxt   = odb_r;
    oavg_nxt  = oavg_r;
    oupd_nxt  = oupd_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    in_bus.ready = 1'b0;

    // magnitude of the incoming sample, most negative value gives exactly 1.0
    if (in_bus.sample[SW-1]) begin
      abs_s = {1'b1, {SW{1'b0}}} - {1'b0, in_bus.sample};
    end else begin
      abs_s = {1'b0, in_bus.sample};
    end

    g_raw = sum[lgt_pkg::ACC_W-1:24];
    if (g_raw < lgt_pkg::AVG_W'(lgt_pkg::GAIN_MIN)) begin
      g_clamp = lgt_pkg::GAIN_MIN;
    end else if (g_raw > lgt_pkg::AVG_W'(lgt_pkg::GAIN_MAX)) begin
      g_clamp = lgt_pkg::GAIN_MAX;
    end else begin
      g_clamp = g_raw[lgt_pkg::GAIN_W-1:0];
    end
    e_pos = '0;
    for (int i = 0; i < lgt_pkg::GAIN_W; i++) begin
      if (g_clamp[i]) e_pos = 5'(i);
    end

    sq     = prod[61:30];
    l2     = {exp_r, frac_r};
    l2_abs = exp_r[2] ? 27'(-l2) : 27'(l2);
    db_rnd = prod[52:0] + (53'd1 << 39);
    db_mag = db_rnd[52:40];

    unique case (state_r)
      lgt_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          mag_nxt   = lgt_pkg::AVG_W'(abs_s) << (lgt_pkg::AVG_W - SW);
          state_nxt = lgt_pkg::ST_AVG_OLD;
        end
      end
      lgt_pkg::ST_AVG_OLD: begin
        mul_a     = lgt_pkg::MUL_W'(avg_r);
        mul_b     = lgt_pkg::MUL_W'(lgt_pkg::AVG_OLD);
        acc_nxt   = prod[lgt_pkg::ACC_W-1:0];
        state_nxt = lgt_pkg::ST_AVG_NEW;
      end
      lgt_pkg::ST_AVG_NEW: begin
        mul_a   = lgt_pkg::MUL_W'(mag_r);
        mul_b   = lgt_pkg::MUL_W'(lgt_pkg::AVG_NEW);
        avg_nxt = sum[lgt_pkg::ACC_W-1:24];
        if (sum[lgt_pkg::ACC_W-1:24] > lgt_pkg::LOUD_THRESHOLD) begin
          upd_nxt   = 1'b1;
          state_nxt = lgt_pkg::ST_DIV_START;
        end else begin
          upd_nxt   = 1'b0;
          state_nxt = lgt_pkg::ST_DONE;
        end
      end
      lgt_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = lgt_pkg::ST_DIV_WAIT;
      end
      lgt_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = lgt_pkg::ST_GAIN_OLD;
      end
      lgt_pkg::ST_GAIN_OLD: begin
        mul_a     = lgt_pkg::MUL_W'(gain_r);
        mul_b     = lgt_pkg::MUL_W'(lgt_pkg::GAIN_OLD);
        acc_nxt   = prod[lgt_pkg::ACC_W-1:0];
        state_nxt = lgt_pkg::ST_GAIN_NEW;
      end
      lgt_pkg::ST_GAIN_NEW: begin
        mul_a    = lgt_pkg::MUL_W'(quo);
        mul_b    = lgt_pkg::MUL_W'(lgt_pkg::GAIN_NEW);
        gain_nxt = g_clamp;
        // normalize into a Q1.30 mantissa for the log
        m_nxt    = lgt_pkg::MUL_W'(g_clamp) << (5'd30 - e_pos);
        exp_nxt  = 3'(e_pos - 5'd16);
        frac_nxt = '0;
        cnt_nxt  = '0;
        state_nxt = lgt_pkg::ST_LOG;
      end
      lgt_pkg::ST_LOG: begin
        mul_a = m_r;
        mul_b = m_r;
        if (sq[31]) begin
          m_nxt    = {1'b0, sq[31:1]};
          frac_nxt = {frac_r[lgt_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          m_nxt    = sq;
          frac_nxt = {frac_r[lgt_pkg::FRAC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lgt_pkg::CNT_W'(lgt_pkg::FRAC_W - 1)) state_nxt = lgt_pkg::ST_DB_MUL;
      end
      lgt_pkg::ST_DB_MUL: begin
        mul_a     = lgt_pkg::MUL_W'(l2_abs);
        mul_b     = lgt_pkg::MUL_W'(lgt_pkg::DB_PER_OCTAVE);
        db_nxt    = exp_r[2] ? lgt_pkg::DB_W'(-db_mag) : db_mag;
        state_nxt = lgt_pkg::ST_DONE;
      end
      lgt_pkg::ST_DONE: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt    = 1'b1;
          og_nxt    = gain_r;
          odb_nxt   = db_r;
          oavg_nxt  = avg_r;
          oupd_nxt  = upd_r;
          state_nxt = lgt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lgt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    acc_r  <= acc_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    upd_r  <= upd_nxt;
    og_r   <= og_nxt;
    odb_r  <= odb_nxt;
    oavg_r <= oavg_nxt;
    oupd_r <= oupd_nxt;
    if (!rst_n) begin
      state_r <= lgt_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      avg_r   <= '0;
      gain_r  <= lgt_pkg::GAIN_ONE;
      db_r    <= '0;
      tgt_r   <= lgt_pkg::TARGET_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      avg_r   <= avg_nxt;
      gain_r  <= gain_nxt;
      db_r    <= db_nxt;
      if (cfg_bus.valid) tgt_r <= cfg_bus.target_level;
    end
  end

  assign cfg_bus.ready        = 1'b1;
  assign out_bus.valid        = ov_r;
  assign out_bus.gain         = og_r;
  assign out_bus.gain_db      = odb_r;
  assign out_bus.loudness     = oavg_r;
  assign out_bus.gain_updated = oupd_r;

  // gain leaves the block only inside the clamp window
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.gain >= lgt_pkg::GAIN_MIN && out_bus.gain <= lgt_pkg::GAIN_MAX))
    else $error("gain out of clamp range");

  // a held gain means the average was at or below threshold
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.gain_updated) |-> out_bus.loudness <= lgt_pkg::LOUD_THRESHOLD)
    else $error("gain held above threshold");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_bus.ready)
    else $error("accepted a sample while busy");

  a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= lgt_pkg::AVG_FULL)
    else $error("magnitude average above full scale");
endmodule

/* test/lgt_checker.sv */
// lgt_checker: watches the sample, result and target channels of the loudness
// gain tracker, predicts each result beat and compares it field by field
// depends on lgt_pkg and the channel interfaces in lgt_if
module lgt_checker (
  input  logic      clk,
  input  logic      rst_n,
  lgt_in_if.sink    in_mon,
  lgt_out_if.sink   out_mon,
  lgt_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending,
  output int        result_count,
  output int        update_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lgt_pkg::GAIN_W-1:0]        gain;
    logic signed [lgt_pkg::DB_W-1:0]   gain_db;
    logic [lgt_pkg::AVG_W-1:0]         loudness;
    logic                              gain_updated;
  } agc_result_t;

  agc_result_t expected_results[$];
  logic [63:0] avg_q, gain_q, target_q;
  logic [lgt_pkg::DB_W-1:0] db_q;

  function automatic logic [lgt_pkg::DB_W-1:0] gain_level_db(logic [63:0] g);
    int e;
    logic [63:0] m, frac, mag, db;
    longint l2;
    e = 0;
    frac = 0;
    while (e < 17 && (g >> (e + 1)) != 0) e++;
    m = g << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    l2 = longint'(e - 16) * (longint'(1) << 24) + longint'(frac);
    mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
    db = (mag * 64'(lgt_pkg::DB_PER_OCTAVE) + (64'd1 << 39)) >> 40;
    if (l2 < 0) db = 64'd0 - db;
    return db[lgt_pkg::DB_W-1:0];
  endfunction

  function automatic agc_result_t track_sample(logic [lgt_pkg::SAMPLE_WIDTH-1:0] s);
    logic [63:0] mag, desired, g;
    agc_result_t r;
    mag = s[lgt_pkg::SAMPLE_WIDTH-1] ?
          ((64'd1 << lgt_pkg::SAMPLE_WIDTH) - 64'(s)) : 64'(s);
    mag = mag << (25 - lgt_pkg::SAMPLE_WIDTH);
    avg_q = (avg_q * 64'(lgt_pkg::AVG_OLD) + mag * 64'(lgt_pkg::AVG_NEW)) >> 24;
    r.gain_updated = 1'b0;
    if (avg_q > 64'(lgt_pkg::LOUD_THRESHOLD)) begin
      desired = (target_q << 24) / avg_q;
      g = (gain_q * 64'(lgt_pkg::GAIN_OLD) + desired * 64'(lgt_pkg::GAIN_NEW)) >> 24;
      if (g < 64'(lgt_pkg::GAIN_MIN)) g = 64'(lgt_pkg::GAIN_MIN);
      if (g > 64'(lgt_pkg::GAIN_MAX)) g = 64'(lgt_pkg::GAIN_MAX);
      gain_q = g;
      db_q = gain_level_db(g);
      r.gain_updated = 1'b1;
    end
    r.gain = gain_q[lgt_pkg::GAIN_W-1:0];
    r.gain_db = db_q;
    r.loudness = avg_q[lgt_pkg::AVG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    agc_result_t want, got;
    if (!rst_n) begin
      avg_q <= 0;
      gain_q <= 64'(lgt_pkg::GAIN_ONE);
      db_q <= '0;
      target_q <= 64'(lgt_pkg::TARGET_RESET);
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      update_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) target_q = 64'(cfg_mon.target_level);
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(track_sample(in_mon.sample));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.gain, out_mon.gain_db, out_mon.loudness, out_mon.gain_updated};
        result_count <= result_count + 1;
        if (got.gain_updated) update_count <= update_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display("beat %0d: expected gain %0d db %0d loud %0d upd %0b, got %0d %0d %0d %0b",
                       result_count, want.gain, want.gain_db, want.loudness,
                       want.gain_updated, got.gain, got.gain_db, got.loudness,
                       got.gain_updated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

/* test/tb_loudness_gain_tracker.sv */
// tb_loudness_gain_tracker: drives samples and target writes into the loudness
// gain tracker with random gaps and stalls; depends on lgt_pkg, lgt_if, lgt_checker
module tb_loudness_gain_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_off = 1'b0;
  int fail_count, pending, result_count, update_count;

  lgt_in_if in_bus ();
  lgt_out_if out_bus ();
  lgt_cfg_if cfg_bus ();

  loudness_gain_tracker DUT (.clk(clk), .rst_n(rst_n), .in_bus(in_bus),
                             .out_bus(out_bus), .cfg_bus(cfg_bus));

  lgt_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
                         .cfg_mon(cfg_bus), .fail_count(fail_count), .pending(pending),
                         .result_count(result_count), .update_count(update_count));

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stall per beat, plus long hold-offs on request
  initial begin
    int wait_cycles;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_bus.ready <= 1'b0;
      else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        repeat (wait_cycles) @(negedge clk);
        out_bus.ready <= 1'b1;
        @(posedge clk);
        while (!out_bus.valid && !hold_off) @(posedge clk);
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
    end
  end

  // valid stays up between back-to-back beats; end_burst drops it
  task automatic send_sample(logic signed [lgt_pkg::SAMPLE_WIDTH-1:0] s, int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      in_bus.sample <= lgt_pkg::SAMPLE_WIDTH'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
    in_bus.sample <= lgt_pkg::SAMPLE_WIDTH'($urandom);
  endtask

  task automatic write_target(logic [lgt_pkg::TGT_W-1:0] t);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.target_level <= t;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // bursts of loud or quiet random audio, with full-scale spikes now and then
  function automatic logic signed [lgt_pkg::SAMPLE_WIDTH-1:0] audio_sample(int level);
    case ($urandom_range(0, 9))
      0: return lgt_pkg::SAMPLE_WIDTH'($urandom);
      1: return $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
      default: return lgt_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 2 * level)) - level);
    endcase
  endfunction

  initial begin
    int level;
    logic [lgt_pkg::TGT_W-1:0] targets[5] = '{16'd0, 16'd65535, 16'd1, 16'd20000, 16'd9830};
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.target_level = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, quiet below threshold, silence
    send_sample(16'sd0, 0);
    send_sample(16'sd1, 0);
    send_sample(-16'sd1, 0);
    send_sample(-16'sd32768, 0);
    send_sample(16'sd32767, 0);
    repeat (8) send_sample(-16'sd32768, 2);
    send_sample(16'sd0, 0);
    send_sample(16'sh5555, 0);
    send_sample(-16'sh5556, 0);
    end_burst();

    // receiver backs off while samples keep coming
    fork
      begin
        repeat (6) send_sample(lgt_pkg::SAMPLE_WIDTH'($urandom), 0);
        end_burst();
      end
      begin
        hold_off <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off <= 1'b0;
      end
    join

    foreach (targets[p]) begin
      write_target(targets[p]);
      repeat (150) begin
        level = (p % 2) ? 32767 : $urandom_range(0, 1) ? 300 : 8000;
        send_sample(audio_sample(level), ($urandom_range(0, 2) == 0) ? 0 : 5);
      end
      end_burst();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d result beats, %0d with a gain update, 5 target settings",
             result_count, update_count);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
